// File: rtl/v3a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared opcodes and default sizes for the vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_DOT   = 4'd4,
    OP_LENSQ = 4'd5,
    OP_LEN   = 4'd6,
    OP_NORM  = 4'd7,
    OP_CROSS = 4'd8
  } v3a_op_e;

endpackage
`default_nettype wire

// File: rtl/v3a_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_lane
// One component lane: two products and their difference, plus add or sub.
// ----------------------------------------------------------------------------
module v3a_lane import v3a_pkg::*; #(
  parameter int unsigned DW = DATA_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire v3a_op_e             op_i,
  input  wire logic signed [DW-1:0] m0a_i,
  input  wire logic signed [DW-1:0] m0b_i,
  input  wire logic signed [DW-1:0] m1a_i,
  input  wire logic signed [DW-1:0] m1b_i,
  input  wire logic signed [DW-1:0] x_i,
  input  wire logic signed [DW-1:0] y_i,
  output logic signed [2*DW:0]      d_o,
  output logic signed [DW:0]        as_o
);

  logic signed [2*DW-1:0] p_q;
  logic signed [2*DW-1:0] q_q;
  logic signed [DW:0]     as1_q;
  logic signed [2*DW:0]   d_q;
  logic signed [DW:0]     as2_q;

  always_ff @(posedge clk_i) begin
    p_q   <= m0a_i * m0b_i;
    q_q   <= m1a_i * m1b_i;
    as1_q <= (op_i == OP_SUB) ? ((DW+1)'(x_i) - (DW+1)'(y_i))
                              : ((DW+1)'(x_i) + (DW+1)'(y_i));
    d_q   <= (2*DW+1)'(p_q) - (2*DW+1)'(q_q);
    as2_q <= as1_q;
  end

  assign d_o  = d_q;
  assign as_o = as2_q;

endmodule
`default_nettype wire

// File: rtl/v3a_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module v3a_sqrt #(
  parameter int unsigned SW = 64,
  parameter int unsigned RW = 32
) (
  input  wire logic          clk_i,
  input  wire logic [SW-1:0] rad_i,
  output logic [RW-1:0]      root_o
);

  logic [SW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic [SW-1:0] rem_p;
    logic [RW-1:0] root_p;
    logic [SW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_p  = rad_i;
      assign root_p = '0;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    // trial term for the next root bit
    assign trial = ((SW+1)'(root_p) << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_p} >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? SW'({1'b0, rem_p} - trial) : rem_p;
      root_q[k] <= take ? (root_p | (RW'(1) << B)) : root_p;
    end
  end

  assign root_o = root_q[RW-1];

endmodule
`default_nettype wire

// File: rtl/v3a_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic [NW-1:0]      quo_o
);

  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [DW-1:0] rem_p;
    logic [NW-1:0] quo_p;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign num_p = num_i;
      assign den_p = den_i;
      assign rem_p = '0;
      assign quo_p = '0;
    end else begin : g_next
      assign num_p = num_q[k-1];
      assign den_p = den_q[k-1];
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {rem_p, num_p[NW-1-k]};
    assign take  = trial >= {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      num_q[k] <= num_p;
      den_q[k] <= den_p;
      rem_q[k] <= take ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
      quo_q[k] <= take ? (quo_p | (NW'(1) << (NW - 1 - k))) : quo_p;
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule
`default_nettype wire

// File: rtl/v3a_dly.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_dly
// Fixed-length delay line for beat control and side data.
// ----------------------------------------------------------------------------
module v3a_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [W-1:0] d_i,
  output logic [W-1:0]      q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) tap_q[i] <= '0;
    end else begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[N-1];

endmodule
`default_nettype wire

// File: rtl/vec3_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vec3_arith_unit
// Every beat passes through the square root and divider stage chains on its way
// from start to done_o, whatever its operation.
// Throughput: one beat per cycle, busy stays low; results cannot be stalled.
// Reset clears all valid bits and the side-data delay lines; other payload registers are not reset.
// ----------------------------------------------------------------------------
module vec3_arith_unit import v3a_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [3:0]                  cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0] ax_i,
  input  wire logic signed [DATA_WIDTH-1:0] ay_i,
  input  wire logic signed [DATA_WIDTH-1:0] az_i,
  input  wire logic signed [DATA_WIDTH-1:0] bx_i,
  input  wire logic signed [DATA_WIDTH-1:0] by_i,
  input  wire logic signed [DATA_WIDTH-1:0] bz_i,
  input  wire logic signed [DATA_WIDTH-1:0] scalar_in_i,
  output logic                             done_o,
  output logic signed [DATA_WIDTH-1:0]     rx_o,
  output logic signed [DATA_WIDTH-1:0]     ry_o,
  output logic signed [DATA_WIDTH-1:0]     rz_o,
  output logic signed [DATA_WIDTH-1:0]     scalar_out_o,
  output logic                             saturated_o,
  output logic                             div_zero_o
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned SW  = 2 * DW;
  localparam int unsigned RW  = DW;
  localparam int unsigned QW  = DW + F;
  localparam int unsigned WW  = (2 * DW + 2 > QW + 1) ? 2 * DW + 2 : QW + 1;
  localparam int unsigned W1  = 8 * DW + 7;
  localparam int unsigned W2  = 4 * DW + 12;
  localparam int unsigned LAT = RW + QW + 5;

  localparam logic signed [WW-1:0] SAT_HI = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [DW:0] sat_f(input logic signed [WW-1:0] v);
    logic [DW:0] res;
    if (v > SAT_HI) begin
      res = {2'b10, {(DW-1){1'b1}}};
    end else if (v < SAT_LO) begin
      res = {2'b11, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, v[DW-1:0]};
    end
    return res;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input beat register
  logic                v0_q;
  v3a_op_e             op0_q;
  logic signed [DW-1:0] a0_q [3];
  logic signed [DW-1:0] b0_q [3];
  logic signed [DW-1:0] s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op0_q   <= v3a_op_e'(cmd_i);
      a0_q[0] <= ax_i;
      a0_q[1] <= ay_i;
      a0_q[2] <= az_i;
      b0_q[0] <= bx_i;
      b0_q[1] <= by_i;
      b0_q[2] <= bz_i;
      s0_q    <= scalar_in_i;
    end
  end

  // lane operand select
  logic signed [DW-1:0] m0a [3];
  logic signed [DW-1:0] m0b [3];
  logic signed [DW-1:0] m1a [3];
  logic signed [DW-1:0] m1b [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m0a[i] = a0_q[i];
      m0b[i] = a0_q[i];
      m1a[i] = '0;
      m1b[i] = '0;
    end
    unique case (op0_q)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) m0b[i] = s0_q;
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) m0b[i] = b0_q[i];
      end
      OP_CROSS: begin
        m0a[0] = a0_q[1]; m0b[0] = b0_q[2]; m1a[0] = a0_q[2]; m1b[0] = b0_q[1];
        m0a[1] = a0_q[2]; m0b[1] = b0_q[0]; m1a[1] = a0_q[0]; m1b[1] = b0_q[2];
        m0a[2] = a0_q[0]; m0b[2] = b0_q[1]; m1a[2] = a0_q[1]; m1b[2] = b0_q[0];
      end
      default: begin
      end
    endcase
  end

  logic signed [2*DW:0] d_l  [3];
  logic signed [DW:0]   as_l [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane #(.DW(DW)) u_lane (
      .clk_i (clk_i),
      .op_i  (op0_q),
      .m0a_i (m0a[i]),
      .m0b_i (m0b[i]),
      .m1a_i (m1a[i]),
      .m1b_i (m1b[i]),
      .x_i   (a0_q[i]),
      .y_i   (b0_q[i]),
      .d_o   (d_l[i]),
      .as_o  (as_l[i])
    );
  end

  // carry along the lane stages
  logic                 v1_q, v2_q;
  v3a_op_e              op1_q, op2_q;
  logic signed [DW-1:0] a1_q [3];
  logic signed [DW-1:0] a2_q [3];
  logic signed [DW-1:0] s1_q, s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= op0_q;
    op2_q <= op1_q;
    s1_q  <= s0_q;
    s2_q  <= s1_q;
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= a0_q[i];
      a2_q[i] <= a1_q[i];
    end
  end

  // merge stage
  logic signed [WW-1:0] sum;
  logic signed [WW-1:0] sum_sh;
  logic [DW:0]          msat [3];
  logic [DW:0]          ssat;
  logic signed [DW-1:0] r3_d [3];
  logic signed [DW-1:0] so3_d;
  logic                 sat3_d, dz3_d;

  assign sum    = WW'(d_l[0]) + WW'(d_l[1]) + WW'(d_l[2]);
  assign sum_sh = sum >>> F;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r3_d[i] = '0;
      msat[i] = sat_f(WW'(as_l[i]));
    end
    ssat   = sat_f(sum_sh);
    so3_d  = '0;
    sat3_d = 1'b0;
    dz3_d  = 1'b0;
    unique case (op2_q)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          r3_d[i] = msat[i][DW-1:0];
          sat3_d  = sat3_d | msat[i][DW];
        end
      end
      OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          msat[i] = sat_f(WW'(d_l[i] >>> F));
          r3_d[i] = msat[i][DW-1:0];
          sat3_d  = sat3_d | msat[i][DW];
        end
      end
      OP_DIV: begin
        dz3_d = (s2_q == '0);
      end
      OP_DOT, OP_LENSQ: begin
        so3_d  = ssat[DW-1:0];
        sat3_d = ssat[DW];
      end
      default: begin
      end
    endcase
  end

  logic                 v3_q;
  v3a_op_e              op3_q;
  logic signed [DW-1:0] a3_q [3];
  logic signed [DW-1:0] s3_q;
  logic signed [DW-1:0] r3_q [3];
  logic signed [DW-1:0] so3_q;
  logic                 sat3_q, dz3_q;
  logic [SW-1:0]        rad3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q  <= op2_q;
    s3_q   <= s2_q;
    so3_q  <= so3_d;
    sat3_q <= sat3_d;
    dz3_q  <= dz3_d;
    rad3_q <= sum[SW-1:0];
    for (int i = 0; i < 3; i++) begin
      a3_q[i] <= a2_q[i];
      r3_q[i] <= r3_d[i];
    end
  end

  // square root with side data alongside
  logic [RW-1:0] root;
  logic [W1-1:0] side1_in, side1_out;

  v3a_sqrt #(.SW(SW), .RW(RW)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad3_q),
    .root_o (root)
  );

  assign side1_in = {v3_q, op3_q, a3_q[0], a3_q[1], a3_q[2], s3_q,
                     r3_q[0], r3_q[1], r3_q[2], so3_q, sat3_q, dz3_q};

  v3a_dly #(.W(W1), .N(RW)) u_dly_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (side1_in),
    .q_o    (side1_out)
  );

  logic                 v4;
  logic [3:0]           op4_raw;
  v3a_op_e              op4;
  logic signed [DW-1:0] a4 [3];
  logic signed [DW-1:0] s4;
  logic signed [DW-1:0] r4 [3];
  logic signed [DW-1:0] so4;
  logic                 sat4, dz4;

  assign {v4, op4_raw, a4[0], a4[1], a4[2], s4, r4[0], r4[1], r4[2], so4, sat4, dz4}
    = side1_out;
  assign op4 = v3a_op_e'(op4_raw);

  // divider operands
  logic [DW-1:0]        den;
  logic [DW-1:0]        amag [3];
  logic [QW-1:0]        num [3];
  logic [DW:0]          lsat;
  logic signed [DW-1:0] so5;
  logic                 sat5, lenz, sneg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = a4[i][DW-1] ? DW'(-a4[i]) : DW'(a4[i]);
      num[i]  = {amag[i], {F{1'b0}}};
    end
    den  = (op4 == OP_NORM) ? root : (s4[DW-1] ? DW'(-s4) : DW'(s4));
    lsat = sat_f({{(WW-RW){1'b0}}, root});
    so5  = (op4 == OP_LEN) ? lsat[DW-1:0] : so4;
    sat5 = sat4 | ((op4 == OP_LEN) & lsat[DW]);
    lenz = (root == '0);
    sneg = (op4 == OP_DIV) & s4[DW-1];
  end

  logic [QW-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(.NW(QW), .DW(DW)) u_div (
      .clk_i (clk_i),
      .num_i (num[i]),
      .den_i (den),
      .quo_o (quo[i])
    );
  end

  logic [W2-1:0] side2_in, side2_out;

  assign side2_in = {v4, op4_raw, a4[0][DW-1], a4[1][DW-1], a4[2][DW-1], sneg,
                     r4[0], r4[1], r4[2], so5, sat5, dz4, lenz};

  v3a_dly #(.W(W2), .N(QW)) u_dly_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (side2_in),
    .q_o    (side2_out)
  );

  logic                 v6;
  logic [3:0]           op6_raw;
  v3a_op_e              op6;
  logic                 an6 [3];
  logic                 sneg6;
  logic signed [DW-1:0] r6 [3];
  logic signed [DW-1:0] so6;
  logic                 sat6, dz6, lenz6;

  assign {v6, op6_raw, an6[0], an6[1], an6[2], sneg6, r6[0], r6[1], r6[2], so6, sat6,
          dz6, lenz6} = side2_out;
  assign op6 = v3a_op_e'(op6_raw);

  // quotient sign, saturation and final select
  logic [QW:0]          qx [3];
  logic signed [QW:0]   qs [3];
  logic [DW:0]          qsat [3];
  logic                 useq;
  logic signed [DW-1:0] rf_d [3];
  logic                 satf_d;

  always_comb begin
    useq   = ((op6 == OP_DIV) && !dz6) || ((op6 == OP_NORM) && !lenz6);
    satf_d = sat6;
    for (int i = 0; i < 3; i++) begin
      qx[i]   = {1'b0, quo[i]};
      qs[i]   = (an6[i] ^ sneg6) ? -qx[i] : qx[i];
      qsat[i] = sat_f(WW'(qs[i]));
      rf_d[i] = useq ? qsat[i][DW-1:0] : r6[i];
      satf_d  = satf_d | (useq & qsat[i][DW]);
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v6) begin
      rx_o         <= rf_d[0];
      ry_o         <= rf_d[1];
      rz_o         <= rf_d[2];
      scalar_out_o <= so6;
      saturated_o  <= satf_d;
      div_zero_o   <= dz6;
    end
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted beat did not complete at fixed latency");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result beat without matching input beat");

  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_zero_o) |-> (rx_o == '0 && ry_o == '0 && rz_o == '0 &&
                                scalar_out_o == '0 && !saturated_o))
    else $error("divide by zero beat carries nonzero data");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vec3_arith_unit: a directed table of edge cases
// followed by random vector beats, each result checked against a bit-exact
// fixed point model (or a table row's typed result), with random gaps between beats.
// ----------------------------------------------------------------------------
module tb_top;
  import v3a_pkg::*;

  localparam int DW  = DATA_WIDTH_DEF;
  localparam int FB  = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1600;
  localparam int N_DIR = 20;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = 1 <<< FB;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [3:0]             cmd;
    logic signed [DW-1:0]   ax, ay, az, bx, by, bz, s;
  } vbeat_t;

  typedef struct packed {
    logic signed [DW-1:0]   rx, ry, rz, so;
    logic                   sat, dz;
  } vres_t;

  typedef struct packed {
    vbeat_t beat;
    logic   typed;
    vres_t  res;
  } vrow_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] cmd_i = '0;
  logic signed [DW-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [DW-1:0] bx_i = '0, by_i = '0, bz_i = '0, scalar_in_i = '0;
  logic done_o, saturated_o, div_zero_o;
  logic signed [DW-1:0] rx_o, ry_o, rz_o, scalar_out_o;

  logic  row_typed = 1'b0;
  vres_t row_res = '0;

  vres_t pending_q[$];
  int    mismatches = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vec3_arith_unit dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i,
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .scalar_in_i,
    .done_o, .rx_o, .ry_o, .rz_o, .scalar_out_o, .saturated_o, .div_zero_o
  );

  function automatic logic signed [DW-1:0] clip(input wide_t v, inout logic f);
    if (v > wide_t'(MAXV)) begin
      f = 1'b1;
      return MAXV;
    end
    if (v < wide_t'(MINV)) begin
      f = 1'b1;
      return MINV;
    end
    return v[DW-1:0];
  endfunction

  function automatic wide_t root_floor(input wide_t sq);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cc = {64'd0, c} * {64'd0, c};
      if (cc <= sq) r = c;
    end
    return wide_t'({64'd0, r});
  endfunction

  function automatic logic signed [DW-1:0] qdiv(input wide_t num, input wide_t d,
                                                inout logic f);
    return clip((num <<< FB) / d, f);
  endfunction

  function automatic wide_t mulw(input logic signed [DW-1:0] a,
                                 input logic signed [DW-1:0] b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  function automatic vres_t vec_result(input vbeat_t t);
    vres_t r;
    wide_t len;
    r = '0;
    case (t.cmd)
      OP_ADD: begin
        r.rx = clip(wide_t'(t.ax) + wide_t'(t.bx), r.sat);
        r.ry = clip(wide_t'(t.ay) + wide_t'(t.by), r.sat);
        r.rz = clip(wide_t'(t.az) + wide_t'(t.bz), r.sat);
      end
      OP_SUB: begin
        r.rx = clip(wide_t'(t.ax) - wide_t'(t.bx), r.sat);
        r.ry = clip(wide_t'(t.ay) - wide_t'(t.by), r.sat);
        r.rz = clip(wide_t'(t.az) - wide_t'(t.bz), r.sat);
      end
      OP_SCALE: begin
        r.rx = clip(mulw(t.ax, t.s) >>> FB, r.sat);
        r.ry = clip(mulw(t.ay, t.s) >>> FB, r.sat);
        r.rz = clip(mulw(t.az, t.s) >>> FB, r.sat);
      end
      OP_DIV: begin
        if (t.s == 0) r.dz = 1'b1;
        else begin
          r.rx = qdiv(wide_t'(t.ax), wide_t'(t.s), r.sat);
          r.ry = qdiv(wide_t'(t.ay), wide_t'(t.s), r.sat);
          r.rz = qdiv(wide_t'(t.az), wide_t'(t.s), r.sat);
        end
      end
      OP_DOT:
        r.so = clip((mulw(t.ax, t.bx) + mulw(t.ay, t.by) + mulw(t.az, t.bz)) >>> FB,
                    r.sat);
      OP_LENSQ:
        r.so = clip((mulw(t.ax, t.ax) + mulw(t.ay, t.ay) + mulw(t.az, t.az)) >>> FB,
                    r.sat);
      OP_LEN:
        r.so = clip(root_floor(mulw(t.ax, t.ax) + mulw(t.ay, t.ay) + mulw(t.az, t.az)),
                    r.sat);
      OP_NORM: begin
        len = root_floor(mulw(t.ax, t.ax) + mulw(t.ay, t.ay) + mulw(t.az, t.az));
        if (len != 0) begin
          r.rx = qdiv(wide_t'(t.ax), len, r.sat);
          r.ry = qdiv(wide_t'(t.ay), len, r.sat);
          r.rz = qdiv(wide_t'(t.az), len, r.sat);
        end
      end
      OP_CROSS: begin
        r.rx = clip((mulw(t.ay, t.bz) - mulw(t.az, t.by)) >>> FB, r.sat);
        r.ry = clip((mulw(t.az, t.bx) - mulw(t.ax, t.bz)) >>> FB, r.sat);
        r.rz = clip((mulw(t.ax, t.by) - mulw(t.ay, t.bx)) >>> FB, r.sat);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [DW-1:0] rand_val();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      7:          return MAXV;
      8:          return MINV;
      default: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return ONE;
          2: return -ONE;
          default: return $signed($urandom_range(0, 8)) - 4;
        endcase
      end
    endcase
  endfunction

  // accept beats and check results
  always @(posedge clk_i) begin
    vres_t got, want;
    if (rst_ni && start && !busy)
      pending_q.push_back(row_typed ? row_res : vec_result({cmd_i, ax_i, ay_i, az_i,
                                                            bx_i, by_i, bz_i,
                                                            scalar_in_i}));
    if (rst_ni && done_o) begin
      got = {rx_o, ry_o, rz_o, scalar_out_o, saturated_o, div_zero_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rx %h/%h ry %h/%h rz %h/%h so %h/%h sat %b/%b dz %b/%b",
                     want.rx, got.rx, want.ry, got.ry, want.rz, got.rz,
                     want.so, got.so, want.sat, got.sat, want.dz, got.dz);
        end
      end
    end
  end

  task automatic send(input vbeat_t t, input logic typed, input vres_t res);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {cmd_i, ax_i, ay_i, az_i, bx_i, by_i, bz_i, scalar_in_i} <= t;
    row_typed <= typed;
    row_res   <= res;
    start     <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    vrow_t  dir_tbl [N_DIR];
    vbeat_t t;
    vres_t  z;
    int     burst;
    z = '0;
    dir_tbl = '{
      '{'{OP_ADD, ONE, -ONE, 3, 2*ONE, ONE, -7, 0}, 1'b0, z},
      '{'{OP_ADD, MAXV, MAXV, MAXV, 1, 1, 1, 0}, 1'b1, '{MAXV, MAXV, MAXV, 0, 1'b1, 1'b0}},
      '{'{OP_SUB, MINV, MINV, MINV, 1, 1, 1, 0}, 1'b1, '{MINV, MINV, MINV, 0, 1'b1, 1'b0}},
      '{'{OP_SUB, 5*ONE, -3, MAXV, ONE, 7, MAXV, 0}, 1'b0, z},
      '{'{OP_SCALE, ONE, -2*ONE, 12345, 0, 0, 0, ONE}, 1'b0, z},
      '{'{OP_SCALE, MAXV, MAXV, MAXV, 0, 0, 0, MAXV}, 1'b1, '{MAXV, MAXV, MAXV, 0, 1'b1, 1'b0}},
      '{'{OP_SCALE, MINV, -1, 3, 0, 0, 0, -1}, 1'b0, z},
      '{'{OP_DIV, ONE, MAXV, MINV, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b1}},
      '{'{OP_DIV, 7*ONE, -ONE, 99, 0, 0, 0, ONE}, 1'b0, z},
      '{'{OP_DIV, MINV, MAXV, -ONE, 0, 0, 0, -1}, 1'b0, z},
      '{'{OP_DOT, ONE, 2*ONE, 3*ONE, 4*ONE, -5*ONE, 6*ONE, 0}, 1'b0, z},
      '{'{OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0}, 1'b1, '{0, 0, 0, MAXV, 1'b1, 1'b0}},
      '{'{OP_LENSQ, ONE, -ONE, ONE, 0, 0, 0, 0}, 1'b0, z},
      '{'{OP_LEN, 3*ONE, 4*ONE, 0, 0, 0, 0, 0}, 1'b0, z},
      '{'{OP_LEN, 0, 0, 0, MAXV, MINV, 1, ONE}, 1'b1, z},
      '{'{OP_NORM, 0, 0, 0, 5, 5, 5, 5}, 1'b1, z},
      '{'{OP_NORM, MINV, 0, 0, 0, 0, 0, 0}, 1'b0, z},
      '{'{OP_NORM, 3, -4, 0, 0, 0, 0, 0}, 1'b0, z},
      '{'{OP_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV, 0}, 1'b0, z},
      '{'{4'd15, MAXV, MINV, -1, -1, MAXV, MINV, -1}, 1'b1, z}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i]) send(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].res);
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      t.cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
      t.ax = rand_val();
      t.ay = rand_val();
      t.az = rand_val();
      t.bx = rand_val();
      t.by = rand_val();
      t.bz = rand_val();
      t.s  = rand_val();
      if (burst > 0) begin
        burst--;
        {cmd_i, ax_i, ay_i, az_i, bx_i, by_i, bz_i, scalar_in_i} <= t;
        row_typed <= 1'b0;
        start     <= 1'b1;
        @(negedge clk_i);
        while (busy) @(negedge clk_i);
        @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 20) == 0) burst = $urandom_range(10, 40);
        send(t, 1'b0, z);
      end
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * DW + FB + 20) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/v3a_pkg.sv
rtl/v3a_lane.sv
rtl/v3a_sqrt.sv
rtl/v3a_div.sv
rtl/v3a_dly.sv
rtl/vec3_arith_unit.sv
bench/tb_top.sv
